// ===== hdl/khsl_pkg.sv =====
// Shared types, constants and control codes for the keyed history sparkline block.
// Used by khsl_front, khsl_fifo, khsl_back and the top level.
package khsl_pkg;

    localparam int DEF_CHANNEL_SLOTS = 8;
    localparam int DEF_HISTORY_DEPTH = 32;
    localparam int KEY_REGS          = 8;
    localparam int KEY_W             = 49;
    localparam int CFG_IDX_W         = 4;
    localparam int SLOT_W            = 3;
    localparam int SAMPLE_W          = 32;
    localparam int LEVEL_W           = 3;
    localparam logic [LEVEL_W-1:0] LEVEL_FLAT = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 3'd7;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_RENDER = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [SLOT_W-1:0]         slot;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MM_RD,
        S_MM_UP,
        S_LV_RD,
        S_LV_SET,
        S_LV_STEP,
        S_OUT
    } t_state;

endpackage

// ===== hdl/khsl_front.sv =====
// Front end: key registers, key match and request classification.
// Depends on khsl_pkg; pushes matched requests and all clear requests into khsl_fifo.
module khsl_front import khsl_pkg::*; #(
    parameter int CHANNEL_SLOTS = DEF_CHANNEL_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [KEY_W-1:0]           i_cfg_data,
    output logic                       o_cfg_clear,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_opcode,
    input  logic [7:0]                 i_key_protocol,
    input  logic [7:0]                 i_key_module,
    input  logic [31:0]                i_key_identifier,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_full,
    output logic                       o_push,
    output t_cmd                       o_cmd
);

    logic [KEY_W-1:0] r_key [KEY_REGS];
    logic [47:0]      key;
    logic             hit;
    logic [SLOT_W-1:0] hit_slot;
    t_op              op;

    assign o_cfg_clear = i_cfg_we && (i_cfg_index < CFG_IDX_W'(KEY_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_REGS; k++) r_key[k] <= '0;
        end else if (o_cfg_clear) begin
            r_key[i_cfg_index[SLOT_W-1:0]] <= i_cfg_data;
        end
    end

    assign key = {i_key_protocol, i_key_module, i_key_identifier};
    assign op  = t_op'(i_opcode);

    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int s = CHANNEL_SLOTS - 1; s >= 0; s--) begin
            if (r_key[s][KEY_W-1] && r_key[s][KEY_W-2:0] == key) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(s);
            end
        end
    end

    assign o_stall = i_full;

    always_comb begin
        o_cmd.op     = op;
        o_cmd.slot   = hit_slot;
        o_cmd.sample = i_sample_value;
        unique case (op)
            OP_RECORD, OP_RENDER: o_push = i_valid && !i_full && hit;
            OP_CLEAR:             o_push = i_valid && !i_full;
            default:              o_push = 1'b0;
        endcase
    end

endmodule

// ===== hdl/khsl_fifo.sv =====
// Two-entry request queue between the front and back ends.
// Depends on khsl_pkg for the request type.
module khsl_fifo import khsl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_cmd   = r_mem[r_rd];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== hdl/khsl_back.sv =====
// Back end: history memory, write pointers, fill counts and the render sequencer.
// Depends on khsl_pkg; pops requests from khsl_fifo and drives the output register.
module khsl_back import khsl_pkg::*; #(
    parameter int CHANNEL_SLOTS = DEF_CHANNEL_SLOTS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_clear,
    input  logic               i_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [LEVEL_W-1:0] o_level,
    output logic               o_last_level
);

    localparam int DW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
    localparam int MD = CHANNEL_SLOTS * HISTORY_DEPTH;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    logic signed [SAMPLE_W-1:0] r_mem [MD];
    logic signed [SAMPLE_W-1:0] r_rdata;

    t_state r_state, n_state;
    logic [DW-1:0] r_wp   [CHANNEL_SLOTS];
    logic [DW-1:0] n_wp   [CHANNEL_SLOTS];
    logic [FW-1:0] r_fill [CHANNEL_SLOTS];
    logic [FW-1:0] n_fill [CHANNEL_SLOTS];
    logic [SW-1:0] r_slot, n_slot;
    logic [FW-1:0] r_count, n_count;
    logic [DW-1:0] r_start, n_start;
    logic [FW-1:0] r_i, n_i;
    logic signed [SAMPLE_W-1:0] r_mn, n_mn, r_mx, n_mx;
    logic [35:0] r_d14, n_d14, r_acc, n_acc;
    logic [31:0] r_rng, n_rng;
    logic [LEVEL_W-1:0] r_lvl, n_lvl;
    logic r_ov, n_ov;
    logic [LEVEL_W-1:0] r_olvl, n_olvl;
    logic r_olast, n_olast;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW:0]   idx_sum;
    logic [DW-1:0] idx;
    logic [SW-1:0] cmd_slot;
    logic [32:0]   diff;
    logic [31:0]   dlt;
    logic          last;

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [DW-1:0] x);
        addr_of = AW'(32'(s) * HISTORY_DEPTH + 32'(x));
    endfunction

    assign cmd_slot = i_cmd.slot[SW-1:0];
    assign idx_sum  = (DW+1)'(r_start) + (DW+1)'(r_i);
    assign idx      = (idx_sum >= (DW+1)'(HISTORY_DEPTH)) ?
                      DW'(idx_sum - (DW+1)'(HISTORY_DEPTH)) : DW'(idx_sum);
    assign diff     = 33'(r_rdata) - 33'(r_mn);
    assign dlt      = diff[31:0];
    assign last     = (r_i == r_count - FW'(1));

    assign o_valid      = r_ov;
    assign o_level      = r_olvl;
    assign o_last_level = r_olast;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= i_cmd.sample;
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state = r_state;
        n_wp    = r_wp;
        n_fill  = r_fill;
        n_slot  = r_slot;
        n_count = r_count;
        n_start = r_start;
        n_i     = r_i;
        n_mn    = r_mn;
        n_mx    = r_mx;
        n_d14   = r_d14;
        n_acc   = r_acc;
        n_rng   = r_rng;
        n_lvl   = r_lvl;
        n_ov    = r_ov && i_stall;
        n_olvl  = r_olvl;
        n_olast = r_olast;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_of(cmd_slot, r_wp[cmd_slot]);
        mem_raddr = addr_of(r_slot, idx);

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_CLEAR: begin
                            for (int s = 0; s < CHANNEL_SLOTS; s++) begin
                                n_wp[s]   = '0;
                                n_fill[s] = '0;
                            end
                        end
                        OP_RECORD: begin
                            mem_we = 1'b1;
                            n_wp[cmd_slot] = (r_wp[cmd_slot] == DW'(HISTORY_DEPTH - 1)) ?
                                             '0 : r_wp[cmd_slot] + DW'(1);
                            if (r_fill[cmd_slot] != FW'(HISTORY_DEPTH))
                                n_fill[cmd_slot] = r_fill[cmd_slot] + FW'(1);
                        end
                        OP_RENDER: begin
                            n_slot  = cmd_slot;
                            n_count = r_fill[cmd_slot];
                            n_start = (r_fill[cmd_slot] == FW'(HISTORY_DEPTH)) ?
                                      r_wp[cmd_slot] : '0;
                            n_i     = '0;
                            if (r_fill[cmd_slot] != '0) n_state = S_MM_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_MM_RD: n_state = S_MM_UP;
            S_MM_UP: begin
                if (r_i == '0 || r_rdata < r_mn) n_mn = r_rdata;
                if (r_i == '0 || r_rdata > r_mx) n_mx = r_rdata;
                if (last) begin
                    n_i     = '0;
                    n_state = S_LV_RD;
                end else begin
                    n_i     = r_i + FW'(1);
                    n_state = S_MM_RD;
                end
            end
            S_LV_RD: begin
                n_rng   = 32'(33'(r_mx) - 33'(r_mn));
                n_state = S_LV_SET;
            end
            S_LV_SET: begin
                n_d14 = (36'(dlt) << 4) - (36'(dlt) << 1);
                n_acc = 36'(r_rng);
                n_lvl = '0;
                if (r_rng == '0) begin
                    n_lvl   = LEVEL_FLAT;
                    n_state = S_OUT;
                end else begin
                    n_state = S_LV_STEP;
                end
            end
            S_LV_STEP: begin
                if (r_lvl == LEVEL_MAX || r_d14 < r_acc) begin
                    n_state = S_OUT;
                end else begin
                    n_lvl = r_lvl + LEVEL_W'(1);
                    n_acc = r_acc + (36'(r_rng) << 1);
                end
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_olvl  = r_lvl;
                    n_olast = last;
                    if (last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + FW'(1);
                        n_state = S_LV_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_clear) begin
            for (int s = 0; s < CHANNEL_SLOTS; s++) begin
                n_wp[s]   = '0;
                n_fill[s] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int s = 0; s < CHANNEL_SLOTS; s++) begin
                r_wp[s]   <= '0;
                r_fill[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_count <= n_count;
        r_start <= n_start;
        r_i     <= n_i;
        r_mn    <= n_mn;
        r_mx    <= n_mx;
        r_d14   <= n_d14;
        r_acc   <= n_acc;
        r_rng   <= n_rng;
        r_lvl   <= n_lvl;
        r_olvl  <= n_olvl;
        r_olast <= n_olast;
    end

endmodule

// ===== hdl/keyed_history_sparkline_levels.sv =====
// Keyed per-channel sample history with sparkline level rendering. A request is taken
// whenever the two-entry queue has room. Record and clear requests are handled in the
// back end's idle state. A render first makes a min/max pass over the stored samples,
// reading and then updating for each, and then emits the levels, each found by a
// serial threshold compare (one of seven thresholds a cycle). Key writes
// empty every history in the same cycle.
module keyed_history_sparkline_levels import khsl_pkg::*; #(
    parameter int CHANNEL_SLOTS = DEF_CHANNEL_SLOTS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [KEY_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_opcode,
    input  logic [7:0]                 i_key_protocol,
    input  logic [7:0]                 i_key_module,
    input  logic [31:0]                i_key_identifier,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [LEVEL_W-1:0]         o_level,
    output logic                       o_last_level
);

    logic cfg_clear;
    logic push, pop, full, empty;
    t_cmd push_cmd, pop_cmd;

    khsl_front #(.CHANNEL_SLOTS(CHANNEL_SLOTS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_cfg_clear(cfg_clear),
        .i_valid, .o_stall, .i_opcode, .i_key_protocol, .i_key_module,
        .i_key_identifier, .i_sample_value,
        .i_full(full), .o_push(push), .o_cmd(push_cmd)
    );

    khsl_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(push), .i_cmd(push_cmd), .i_pop(pop),
        .o_cmd(pop_cmd), .o_full(full), .o_empty(empty)
    );

    khsl_back #(.CHANNEL_SLOTS(CHANNEL_SLOTS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cfg_clear(cfg_clear),
        .i_empty(empty), .i_cmd(pop_cmd), .o_pop(pop),
        .o_valid, .i_stall, .o_level, .o_last_level
    );

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("push into full queue");
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(full && empty)) else $error("queue both full and empty");
`endif

endmodule

// ===== test/keyed_history_sparkline_levels_chk.sv =====
// Checker for keyed_history_sparkline_levels: watches the request and level channels,
// predicts the levels from its own key table and histories, and counts mismatches.
// Depends on khsl_pkg for the opcode enum and port widths.
module keyed_history_sparkline_levels_chk import khsl_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [KEY_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    input  logic                       i_stall_req,
    input  logic [1:0]                 i_opcode,
    input  logic [7:0]                 i_key_protocol,
    input  logic [7:0]                 i_key_module,
    input  logic [31:0]                i_key_identifier,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_lvl_valid,
    input  logic                       i_lvl_stall,
    input  logic [LEVEL_W-1:0]         i_level,
    input  logic                       i_last_level,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_levels_seen
);
    localparam int SLOTS = 8;
    localparam int DEPTH = 32;

    logic [KEY_W-1:0]         key_tbl [SLOTS];
    logic signed [31:0]       hist    [SLOTS][DEPTH];
    logic [4:0]               wptr    [SLOTS];
    logic [5:0]               fill    [SLOTS];
    logic [LEVEL_W:0]         level_q [$];

    initial begin
        o_errors = 0;
        o_levels_seen = 0;
    end
    assign o_pending = level_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    task automatic clear_all();
        for (int s = 0; s < SLOTS; s++) begin
            wptr[s] = '0;
            fill[s] = '0;
        end
    endtask

    function automatic int find_slot(input logic [47:0] key);
        for (int s = 0; s < SLOTS; s++)
            if (key_tbl[s][48] && key_tbl[s][47:0] == key) return s;
        return -1;
    endfunction

    task automatic predict_request(input t_op op, input logic [47:0] key,
                                   input logic signed [31:0] smp);
        int slot, cnt, start;
        longint mn, mx, v, d, r, lv;
        if (op == OP_CLEAR) begin
            clear_all();
            return;
        end
        if (op == OP_NONE) return;
        slot = find_slot(key);
        if (slot < 0) return;
        if (op == OP_RECORD) begin
            hist[slot][wptr[slot]] = smp;
            wptr[slot] = wptr[slot] + 5'd1;
            if (fill[slot] < DEPTH) fill[slot]++;
            return;
        end
        cnt = fill[slot];
        if (cnt == 0) return;
        start = (cnt < DEPTH) ? 0 : wptr[slot];
        mn = hist[slot][start];
        mx = mn;
        for (int i = 1; i < cnt; i++) begin
            v = hist[slot][(start + i) % DEPTH];
            if (v < mn) mn = v;
            if (v > mx) mx = v;
        end
        for (int i = 0; i < cnt; i++) begin
            v = hist[slot][(start + i) % DEPTH];
            lv = 3;
            if (mx > mn) begin
                d = v - mn;
                r = mx - mn;
                lv = (14 * d + r) / (2 * r);
                if (lv > 7) lv = 7;
            end
            level_q.push_back({lv[2:0], i + 1 == cnt});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) key_tbl[s] = '0;
            clear_all();
            level_q.delete();
        end else begin
            if (i_lvl_valid && !i_lvl_stall) begin
                o_levels_seen++;
                if (level_q.size() == 0) begin
                    report("unexpected level", i_level, -1);
                end else begin
                    if (i_level != level_q[0][3:1])
                        report("level", i_level, level_q[0][3:1]);
                    if (i_last_level != level_q[0][0])
                        report("last_level", i_last_level, level_q[0][0]);
                    void'(level_q.pop_front());
                end
            end
            if (i_cfg_we && i_cfg_index < KEY_REGS) begin
                key_tbl[i_cfg_index[2:0]] = i_cfg_data;
                clear_all();
            end
            if (i_valid && !i_stall_req)
                predict_request(t_op'(i_opcode),
                                {i_key_protocol, i_key_module, i_key_identifier},
                                i_sample_value);
        end
    end
endmodule

// ===== test/keyed_history_sparkline_levels_tb.sv =====
// Testbench top for keyed_history_sparkline_levels: drives key writes and
// record/render/clear requests with random idling, and reports the verdict.
// Depends on khsl_pkg and keyed_history_sparkline_levels_chk.
module keyed_history_sparkline_levels_tb;
    import khsl_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_data;
    logic                 req_valid;
    logic                 req_stall;
    logic [1:0]           req_op;
    logic [7:0]           req_prot;
    logic [7:0]           req_mod;
    logic [31:0]          req_id;
    logic signed [31:0]   req_sample;
    logic                 lvl_valid;
    logic                 lvl_stall;
    logic [LEVEL_W-1:0]   lvl_level;
    logic                 lvl_last;
    int                   errors;
    int                   pending;
    int                   levels_seen;
    int                   requests_sent;
    bit                   quiet;

    logic [47:0]          keys [8];

    keyed_history_sparkline_levels DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_stall(req_stall), .i_opcode(req_op),
        .i_key_protocol(req_prot), .i_key_module(req_mod), .i_key_identifier(req_id),
        .i_sample_value(req_sample),
        .o_valid(lvl_valid), .i_stall(lvl_stall), .o_level(lvl_level),
        .o_last_level(lvl_last)
    );

    keyed_history_sparkline_levels_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_stall_req(req_stall), .i_opcode(req_op),
        .i_key_protocol(req_prot), .i_key_module(req_mod), .i_key_identifier(req_id),
        .i_sample_value(req_sample),
        .i_lvl_valid(lvl_valid), .i_lvl_stall(lvl_stall), .i_level(lvl_level),
        .i_last_level(lvl_last),
        .o_errors(errors), .o_pending(pending), .o_levels_seen(levels_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("** keyed_history_sparkline_levels: FAILED **");
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) lvl_stall <= 1'b0;
        else lvl_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end

    task automatic write_key(input int idx, input logic [KEY_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send(input t_op op, input logic [47:0] key, input logic [31:0] smp);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req_valid  <= 1'b1;
        req_op     <= op;
        req_prot   <= key[47:40];
        req_mod    <= key[39:32];
        req_id     <= key[31:0];
        req_sample <= smp;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
        req_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_keys(input bit extreme);
        for (int s = 0; s < 8; s++) begin
            keys[s] = extreme ? ((s % 2) ? 48'hFFFF_FFFF_FFFF : 48'(s))
                              : 48'({$urandom, $urandom});
            write_key(s, {($urandom_range(0, 5) != 0), keys[s]});
        end
    endtask

    initial begin
        logic [47:0] k;
        int r;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        req_valid = 1'b0; req_op = '0; req_prot = '0; req_mod = '0; req_id = '0;
        req_sample = '0; lvl_stall = 1'b0; quiet = 1'b0; requests_sent = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(OP_RENDER, 48'h0, 32'h0);
        for (int s = 0; s < 8; s++) begin
            keys[s] = (s == 7) ? 48'hFFFF_FFFF_FFFF : {8'(s), 8'(s * 3), 32'(s)};
            write_key(s, {1'b1, keys[s]});
        end
        keys[6] = keys[2];
        write_key(6, {1'b1, keys[6]});
        write_key(9, {1'b1, 48'h0});
        send(OP_RECORD, keys[0], 32'h8000_0000);
        send(OP_RECORD, keys[0], 32'h7FFF_FFFF);
        send(OP_RECORD, keys[0], 32'h0);
        send(OP_RENDER, keys[0], 32'h0);
        send(OP_RECORD, keys[2], 32'h0001_0000);
        send(OP_RECORD, keys[2], 32'h0001_0000);
        send(OP_RENDER, keys[2], 32'h0);
        send(OP_RECORD, keys[7], 32'hFFFF_FFFF);
        send(OP_RENDER, keys[7], 32'h0);
        send(OP_RECORD, 48'hDEAD_BEEF_0000, 32'h5);
        send(OP_RENDER, 48'hDEAD_BEEF_0000, 32'h0);
        send(OP_NONE, keys[0], 32'h0);
        send(OP_RENDER, keys[3], 32'h0);
        for (int i = 0; i < 35; i++) send(OP_RECORD, keys[1], $urandom_range(0, 20));
        send(OP_RENDER, keys[1], 32'h0);
        send(OP_CLEAR, keys[1], 32'h0);
        send(OP_RENDER, keys[1], 32'h0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            quiet = (ph == 2);
            load_keys(ph == 4);
            for (int i = 0; i < 80; i++) begin
                r = $urandom_range(0, 99);
                k = keys[$urandom_range(0, 7)];
                if (r < 4) k = 48'({$urandom, $urandom});
                if (r < 70) send(OP_RECORD, k, rand_sample());
                else if (r < 92) send(OP_RENDER, k, $urandom);
                else if (r < 96) send(OP_CLEAR, k, $urandom);
                else send(OP_NONE, k, $urandom);
            end
            drain();
        end
        quiet = 1'b0;

        $display("covered %0d requests, %0d levels, six key settings", requests_sent,
                 levels_seen);
        if (errors == 0) begin
            $display("** keyed_history_sparkline_levels: PASSED **");
        end else begin
            $display("** keyed_history_sparkline_levels: FAILED **");
        end
        $finish;
    end
endmodule
